FILE: design/multi_timer_table_unit_defines.svh
// Assertion macros for the timer table top level
`ifndef MULTI_TIMER_TABLE_UNIT_DEFINES_SVH
`define MULTI_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define MTT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("timer table check failed");

// cause in one cycle implies effect in the next
`define MTT_ASSERT_NEXT(lbl, clk, rstn, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cause) |=> (effect)) \
    else $error("timer table sequence check failed");

`else

`define MTT_ASSERT(lbl, clk, rstn, prop)
`define MTT_ASSERT_NEXT(lbl, clk, rstn, cause, effect)

`endif

`endif

FILE: design/mtt_pkg.sv
// Types, codes and helpers for the timer table
package mtt_pkg;

  localparam int TIME_W = 48;
  localparam int DUR_W  = 31;
  localparam int SLOT_W = 5;
  localparam int NEXT_W = 32;

  typedef enum logic [1:0] {
    ACT_ADD_ONE = 2'd0,
    ACT_ADD_PER = 2'd1,
    ACT_CANCEL  = 2'd2,
    ACT_SCAN    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_FIRED  = 2'd0,
    EV_REPORT = 2'd1,
    EV_ADD    = 2'd2,
    EV_CANCEL = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_INACTIVE = 2'd2
  } status_e;

  localparam logic [DUR_W-1:0]  REMAIN_MAX = {DUR_W{1'b1}};
  localparam logic [NEXT_W-1:0] NONE_LEFT  = {NEXT_W{1'b1}};

  typedef struct packed {
    event_e              kind;
    logic [SLOT_W-1:0]   slot;
    status_e             status;
    logic [NEXT_W-1:0]   next;
    logic                last;
  } mtt_res_t;

  // now plus a duration, saturated at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] now,
                                                input logic [DUR_W-1:0]  dur);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

FILE: design/mtt_ram.sv
// Single-port-write, registered-read memory for deadlines and periods
module mtt_ram #(
  parameter int Depth = 32,
  parameter int Width = 79,
  parameter int AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mtt_out.sv
// Output register stage for result transfers
module mtt_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mtt_pkg::mtt_res_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_kind_o,
  output logic [4:0]        timer_slot_o,
  output logic [1:0]        status_o,
  output logic signed [31:0] next_timeout_ms_o,
  output logic              last_o
);
  import mtt_pkg::*;

  logic     vld_q;
  mtt_res_t res_q;

  assign free_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o       = vld_q;
  assign event_kind_o      = res_q.kind;
  assign timer_slot_o      = res_q.slot;
  assign status_o          = res_q.status;
  assign next_timeout_ms_o = $signed(res_q.next);
  assign last_o            = res_q.last;

endmodule

FILE: design/multi_timer_table_unit.sv
// Timer table top level: sequencer over the deadline/period memory
//
// Keeps TIMER_SLOTS timers, one-shot or periodic, with deadline and period held in
// a synchronous memory and the armed flags in flip-flops. Add and cancel pass
// through S_EXEC to the output register. A scan walks the used slots in order:
// an unarmed slot is skipped in S_RD, an armed one goes through S_RD and S_EV
// (memory read, then compare, reschedule and write back), and the final report
// is sent from S_RPT. Result transfers stalled downstream hold the sequencer. A
// new input is taken only once the previous one has finished its work; its
// results may still be waiting in the output register.
module multi_timer_table_unit #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [47:0]        now_ms_i,
  input  logic [30:0]        duration_ms_i,
  input  logic [4:0]         slot_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         event_kind_o,
  output logic [4:0]         timer_slot_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] next_timeout_ms_o,
  output logic               last_o
);
  import mtt_pkg::*;
  `include "multi_timer_table_unit_defines.svh"

  localparam int SW    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int UW    = $clog2(TIMER_SLOTS + 1);
  localparam int ENT_W = TIME_W + DUR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_RPT  = 3'd4;

  logic [2:0]             state_q, state_d;
  action_e                act_q;
  logic [TIME_W-1:0]      now_q;
  logic [DUR_W-1:0]       dur_q;
  logic [SLOT_W-1:0]      sid_q;
  logic [UW-1:0]          used_q, used_d;
  logic [UW-1:0]          idx_q, idx_d;
  logic [TIMER_SLOTS-1:0] armed_q, armed_d;
  logic                   pend_q, pend_d;
  logic                   any_q, any_d;
  logic [DUR_W-1:0]       best_q, best_d;
  logic [TIME_W-1:0]      dl_q, dl_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;
  mtt_res_t               res;
  logic                   mem_we;
  logic [SW-1:0]          mem_waddr;
  logic [ENT_W-1:0]       mem_wdata;
  logic [ENT_W-1:0]       mem_rdata;
  logic [TIME_W-1:0]      rd_dl;
  logic [DUR_W-1:0]       rd_per;
  logic [TIME_W-1:0]      diff;
  logic [DUR_W-1:0]       rem;
  logic [TIME_W-1:0]      resched;
  logic                   fire;
  logic                   full;
  logic                   sid_hit;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign rd_dl  = mem_rdata[ENT_W-1:DUR_W];
  assign rd_per = mem_rdata[DUR_W-1:0];

  assign diff    = dl_q - now_q;
  assign rem     = (dl_q > now_q) ? ((|diff[TIME_W-1:DUR_W]) ? REMAIN_MAX : diff[DUR_W-1:0])
                                  : '0;
  assign fire    = (now_q >= rd_dl);
  assign resched = sat_add(now_q, rd_per);
  assign full    = (used_q >= UW'(TIMER_SLOTS));
  assign sid_hit = ({1'b0, sid_q} < (SLOT_W+1)'(TIMER_SLOTS)) && armed_q[SW'(sid_q)];

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    idx_d     = idx_q;
    armed_d   = armed_q;
    pend_d    = pend_q;
    any_d     = any_q;
    best_d    = best_q;
    dl_d      = dl_q;
    mem_we    = 1'b0;
    mem_waddr = SW'(used_q);
    mem_wdata = {sat_add(now_q, dur_q), (act_q == ACT_ADD_PER) ? dur_q : '0};
    out_load  = 1'b0;
    res       = '{kind: EV_REPORT, slot: '0, status: ST_OK, next: '0, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (action_e'(action_i) == ACT_SCAN) ? S_RD : S_EXEC;
          idx_d   = '0;
          any_d   = 1'b0;
          pend_d  = 1'b0;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (act_q == ACT_CANCEL) begin
            res.kind = EV_CANCEL;
            res.slot = sid_q;
            if (sid_hit) begin
              armed_d[SW'(sid_q)] = 1'b0;
            end else begin
              res.status = ST_INACTIVE;
            end
          end else begin
            res.kind = EV_ADD;
            if (full || (act_q == ACT_ADD_PER && dur_q == '0)) begin
              res.status = ST_REJECT;
            end else begin
              mem_we               = 1'b1;
              armed_d[SW'(used_q)] = 1'b1;
              used_d               = used_q + 1'b1;
              res.slot             = SLOT_W'(used_q);
            end
          end
        end
      end
      S_RD: begin
        if (pend_q) begin
          pend_d = 1'b0;
          if (!any_q || rem < best_q) begin
            best_d = rem;
            any_d  = 1'b1;
          end
        end
        if (idx_q >= used_q) begin
          state_d = S_RPT;
        end else if (!armed_q[SW'(idx_q)]) begin
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = S_EV;
        end
      end
      S_EV: begin
        if (!fire || out_free) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
          pend_d  = 1'b1;
          dl_d    = rd_dl;
          if (fire) begin
            out_load   = 1'b1;
            res.kind   = EV_FIRED;
            res.slot   = SLOT_W'(idx_q);
            res.last   = 1'b0;
            if (rd_per != '0) begin
              mem_we    = 1'b1;
              mem_waddr = SW'(idx_q);
              mem_wdata = {resched, rd_per};
              dl_d      = resched;
            end else begin
              armed_d[SW'(idx_q)] = 1'b0;
              pend_d              = 1'b0;
            end
          end
        end
      end
      S_RPT: begin
        if (out_free) begin
          out_load = 1'b1;
          res.next = any_q ? {1'b0, best_q} : NONE_LEFT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
      armed_q <= '0;
      pend_q  <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      armed_q <= armed_d;
      pend_q  <= pend_d;
      any_q   <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_e'(action_i);
      now_q <= now_ms_i;
      dur_q <= duration_ms_i;
      sid_q <= slot_id_i;
    end
    best_q <= best_d;
    dl_q   <= dl_d;
  end

  mtt_ram #(
    .Depth (TIMER_SLOTS),
    .Width (ENT_W),
    .AddrW (SW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (SW'(idx_q)),
    .rdata_o (mem_rdata)
  );

  mtt_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (out_load),
    .res_i             (res),
    .free_o            (out_free),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_kind_o      (event_kind_o),
    .timer_slot_o      (timer_slot_o),
    .status_o          (status_o),
    .next_timeout_ms_o (next_timeout_ms_o),
    .last_o            (last_o)
  );

  `MTT_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= UW'(TIMER_SLOTS))
  `MTT_ASSERT(a_idx_bound, clk_i, rst_ni, (state_q == S_IDLE) || (state_q == S_EXEC) || (idx_q <= used_q))
  `MTT_ASSERT(a_we_state, clk_i, rst_ni, !mem_we || (state_q == S_EXEC) || (state_q == S_EV))
  `MTT_ASSERT(a_load_free, clk_i, rst_ni, !out_load || out_free)
  `MTT_ASSERT_NEXT(a_rpt_done, clk_i, rst_ni, (state_q == S_RPT) && out_free, state_q == S_IDLE)

endmodule

FILE: bench/multi_timer_table_unit_tb.sv
// Self-checking testbench for the timer table: directed and random actions against a predictor
module multi_timer_table_unit_tb;
  import mtt_pkg::*;

  localparam int TIMER_SLOTS = 32;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall_o;
  action_e            action_q;
  logic [47:0]        now_q;
  logic [30:0]        dur_q;
  logic [4:0]         sid_q;
  logic               out_valid_o;
  logic               out_stall;
  logic [1:0]         event_kind_o;
  logic [4:0]         timer_slot_o;
  logic [1:0]         status_o;
  logic signed [31:0] next_timeout_ms_o;
  logic               last_o;

  logic [47:0] timer_deadline [TIMER_SLOTS];
  logic [30:0] timer_period [TIMER_SLOTS];
  logic        timer_armed [TIMER_SLOTS];
  int          slots_taken;
  mtt_res_t    expected_events [$];
  logic [47:0] clock_ms;
  int          errors;
  int          idle_cycles;
  bit          calm;

  multi_timer_table_unit #(.TIMER_SLOTS(TIMER_SLOTS)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .action_i         (action_q),
    .now_ms_i         (now_q),
    .duration_ms_i    (dur_q),
    .slot_id_i        (sid_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .event_kind_o     (event_kind_o),
    .timer_slot_o     (timer_slot_o),
    .status_o         (status_o),
    .next_timeout_ms_o(next_timeout_ms_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [47:0] deadline_after(logic [47:0] now, logic [30:0] dur);
    logic [48:0] sum;
    sum = now + dur;
    return sum[48] ? {48{1'b1}} : sum[47:0];
  endfunction

  // apply one accepted action to the shadow table and queue its results
  task automatic predict_action(action_e act, logic [47:0] now, logic [30:0] dur,
                                logic [4:0] sid);
    mtt_res_t    r;
    logic [47:0] left;
    logic [47:0] best;
    bit          any;
    r    = '{kind: EV_ADD, slot: '0, status: ST_OK, next: '0, last: 1'b1};
    any  = 1'b0;
    best = '0;
    case (act)
      ACT_ADD_ONE, ACT_ADD_PER: begin
        if (slots_taken >= TIMER_SLOTS || (act == ACT_ADD_PER && dur == '0)) begin
          r.status = ST_REJECT;
        end else begin
          timer_deadline[slots_taken] = deadline_after(now, dur);
          timer_period[slots_taken]   = (act == ACT_ADD_PER) ? dur : '0;
          timer_armed[slots_taken]    = 1'b1;
          r.slot = slots_taken[4:0];
          slots_taken++;
        end
        expected_events.push_back(r);
      end
      ACT_CANCEL: begin
        r.kind = EV_CANCEL;
        r.slot = sid;
        if (timer_armed[sid]) timer_armed[sid] = 1'b0;
        else r.status = ST_INACTIVE;
        expected_events.push_back(r);
      end
      default: begin
        for (int i = 0; i < slots_taken; i++) begin
          if (timer_armed[i]) begin
            if (now >= timer_deadline[i]) begin
              expected_events.push_back('{kind: EV_FIRED, slot: i[4:0], status: ST_OK,
                                          next: '0, last: 1'b0});
              if (timer_period[i] != '0) timer_deadline[i] = deadline_after(now, timer_period[i]);
              else timer_armed[i] = 1'b0;
            end
            if (timer_armed[i]) begin
              left = (timer_deadline[i] > now) ? timer_deadline[i] - now : '0;
              if (left > REMAIN_MAX) left = REMAIN_MAX;
              if (!any || left < best) begin
                best = left;
                any  = 1'b1;
              end
            end
          end
        end
        r.kind = EV_REPORT;
        r.next = any ? best[31:0] : NONE_LEFT;
        expected_events.push_back(r);
      end
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_action(action_e act, logic [47:0] now, logic [30:0] dur, logic [4:0] sid);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    action_q <= act;
    now_q    <= now;
    dur_q    <= dur;
    sid_q    <= sid;
    do @(posedge clk_i); while (in_stall_o);
    predict_action(act, now, dur, sid);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    mtt_res_t w;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected result, kind", event_kind_o, -1);
      end else begin
        w = expected_events.pop_front();
        if (event_kind_o !== w.kind) report_mismatch("event_kind", event_kind_o, w.kind);
        if (timer_slot_o !== w.slot) report_mismatch("timer_slot", timer_slot_o, w.slot);
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (next_timeout_ms_o !== w.next)
          report_mismatch("next_timeout_ms", next_timeout_ms_o, signed'(w.next));
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d results still outstanding", expected_events.size());
      $display("** multi_timer_table_unit: FAILED **");
      $finish;
    end
  end

  // downstream stall in bursts, with open stretches between
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_idle_table;
    send_action(ACT_SCAN, '0, '0, '0);
    send_action(ACT_CANCEL, '0, '0, 5'd0);
    send_action(ACT_CANCEL, '0, '1, 5'd31);
    send_action(ACT_ADD_PER, '0, '0, '0);
  endtask

  task automatic test_adds;
    send_action(ACT_ADD_ONE, '0, '0, '0);
    send_action(ACT_ADD_PER, '0, 31'd10, '0);
    send_action(ACT_ADD_ONE, '1, '1, '1);
    send_action(ACT_ADD_PER, 48'd100, '1, '0);
  endtask

  task automatic test_firing;
    send_action(ACT_SCAN, '0, '0, '0);
    send_action(ACT_SCAN, 48'd10, '0, '0);
  endtask

  task automatic test_cancel;
    send_action(ACT_CANCEL, '0, '0, 5'd1);
    send_action(ACT_CANCEL, '0, '0, 5'd1);
    send_action(ACT_CANCEL, '0, '0, 5'd0);
  endtask

  // deadlines and remaining time at the top of their ranges
  task automatic test_saturation;
    send_action(ACT_SCAN, '1, '0, '0);
    send_action(ACT_SCAN, 48'd5, '0, '0);
  endtask

  task automatic test_random_traffic(int count);
    int          pick;
    action_e     act;
    logic [47:0] now;
    logic [30:0] dur;
    logic [4:0]  sid;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      dur  = 31'($urandom());
      sid  = 5'($urandom());
      now  = clock_ms;
      if (pick < 12) begin
        act = $urandom_range(0, 1) ? ACT_ADD_PER : ACT_ADD_ONE;
        dur = 31'($urandom_range(1, 120));
        case ($urandom_range(0, 9))
          0: dur = '0;
          1: dur = 31'($urandom_range(0, 5000));
          2: dur = 31'($urandom());
          3: now = {16'($urandom()), 32'($urandom())};
          default: ;
        endcase
      end else if (pick < 32) begin
        act = ACT_CANCEL;
        if (slots_taken > 0 && $urandom_range(0, 3) != 0)
          sid = 5'($urandom_range(0, slots_taken - 1));
      end else begin
        act = ACT_SCAN;
        if ($urandom_range(0, 9) == 0) begin
          now = clock_ms - 48'($urandom_range(0, 30));
        end else begin
          clock_ms += 48'($urandom_range(0, 50));
          now = clock_ms;
        end
      end
      send_action(act, now, dur, sid);
    end
  endtask

  task automatic test_table_full;
    while (slots_taken < TIMER_SLOTS) begin
      send_action(ACT_ADD_PER, clock_ms, 31'($urandom_range(1, 200)), '0);
    end
    send_action(ACT_ADD_ONE, clock_ms, 31'd7, '0);
    send_action(ACT_ADD_PER, clock_ms, 31'd7, '0);
  endtask

  initial begin
    in_valid    = 1'b0;
    action_q    = ACT_SCAN;
    now_q       = '0;
    dur_q       = '0;
    sid_q       = '0;
    slots_taken = 0;
    clock_ms    = 48'd1000;
    errors      = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    foreach (timer_armed[i]) timer_armed[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_table();
    test_adds();
    test_firing();
    test_cancel();
    test_saturation();
    test_random_traffic(373);
    test_table_full();
    calm = 1'b1;
    test_random_traffic(40);
    in_valid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("** multi_timer_table_unit: PASSED **");
    end else begin
      $display("** multi_timer_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
